// ----- hw/rtl/tga_rle_pkg.sv -----
// Shared constants for the TGA run-length pixel decoder.
package tga_rle_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH_CODED = 8'd3;

  localparam logic [1:0] BYTE_BLUE  = 2'd0;
  localparam logic [1:0] BYTE_GREEN = 2'd1;
  localparam logic [1:0] BYTE_RED   = 2'd2;
  localparam logic [1:0] BYTE_ALPHA = 2'd3;

  localparam logic [7:0] RUN_HDR_MIN  = 8'd128;
  localparam logic [7:0] RUN_HDR_BIAS = 8'd127;
  localparam int unsigned PIX_HELD_W  = 24;

endpackage

// ----- hw/rtl/tga_rle_pixel_decoder_top.sv -----
// TGA pixel-data decoder: run-length packet parser, BGR(A) to RGB(A) swap, pixel counting.
// A pixel's result enters the output register at the edge that accepts its last byte.
// Throughput: one byte per cycle unless out_ready stalls; parser state and output register
// update together, and the output register refills in the cycle it is taken.
// Reset (rst_n low, synchronous): width 1, height 1, no alpha, run-length mode, expect header.
// A write to any of the four config registers restarts the image; the size product is formed at the write.
module tga_rle_pixel_decoder_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_data_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_red,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_blue,
  output logic [7:0]                           out_alpha,
  output logic [31:0]                          out_first_pixel,
  output logic [7:0]                           out_repeat_count,
  output logic                                 out_image_done
);
  import tga_rle_pkg::*;

  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        alpha_en_r, alpha_en_nxt;
  logic        rle_r, rle_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic        is_run_r, is_run_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [PIX_HELD_W-1:0] held_r, held_nxt;
  logic [31:0] decoded_r, decoded_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  alpha_r, alpha_nxt;
  logic [31:0] first_r, first_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        done_r, done_nxt;

  logic        in_acc;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] size_prod;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign mul_a     = (cfg_index == CFG_IMAGE_WIDTH)  ? cfg_wdata : width_r;
  assign mul_b     = (cfg_index == CFG_IMAGE_HEIGHT) ? cfg_wdata : height_r;
  assign size_prod = {16'd0, mul_a} * {16'd0, mul_b};

  always_comb begin
    logic       last;
    logic [7:0] cnt;
    logic [7:0] left_after;
    width_nxt    = width_r;
    height_nxt   = height_r;
    alpha_en_nxt = alpha_en_r;
    rle_nxt      = rle_r;
    awaiting_nxt = awaiting_r;
    is_run_nxt   = is_run_r;
    pkt_left_nxt = pkt_left_r;
    bip_nxt      = bip_r;
    held_nxt     = held_r;
    decoded_nxt  = decoded_r;
    remain_nxt   = remain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    alpha_nxt = alpha_r;
    first_nxt = first_r;
    count_nxt = count_r;
    done_nxt  = done_r;
    last       = alpha_en_r ? (bip_r == BYTE_ALPHA) : (bip_r >= BYTE_RED);
    cnt        = 8'd1;
    left_after = pkt_left_r;

    if (cfg_wr_en && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT ||
        cfg_index == CFG_HAS_ALPHA || cfg_index == CFG_RUN_LENGTH_CODED)) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_nxt    = cfg_wdata;
        CFG_IMAGE_HEIGHT: height_nxt   = cfg_wdata;
        CFG_HAS_ALPHA:    alpha_en_nxt = cfg_wdata[0];
        default:          rle_nxt      = cfg_wdata[0];
      endcase
      awaiting_nxt = 1'b1;
      is_run_nxt   = 1'b0;
      pkt_left_nxt = '0;
      bip_nxt      = BYTE_BLUE;
      held_nxt     = '0;
      decoded_nxt  = '0;
      remain_nxt   = size_prod;
    end else if (in_acc && remain_r != 32'd0) begin
      if (rle_r && awaiting_r) begin
        if (in_data_byte < RUN_HDR_MIN) begin
          is_run_nxt   = 1'b0;
          pkt_left_nxt = in_data_byte + 8'd1;
        end else begin
          is_run_nxt   = 1'b1;
          pkt_left_nxt = in_data_byte - RUN_HDR_BIAS;
        end
        awaiting_nxt = 1'b0;
        bip_nxt      = BYTE_BLUE;
        held_nxt     = '0;
      end else if (!last) begin
        case (bip_r)
          BYTE_BLUE:  held_nxt[7:0]   = held_r[7:0]   | in_data_byte;
          BYTE_GREEN: held_nxt[15:8]  = held_r[15:8]  | in_data_byte;
          BYTE_RED:   held_nxt[23:16] = held_r[23:16] | in_data_byte;
          default:    held_nxt        = held_r;
        endcase
        bip_nxt = bip_r + 2'd1;
      end else begin
        blue_nxt  = held_r[7:0];
        green_nxt = held_r[15:8];
        if (bip_r == BYTE_RED) begin
          red_nxt   = in_data_byte;
          alpha_nxt = 8'd0;
        end else begin
          red_nxt   = held_r[23:16];
          alpha_nxt = alpha_en_r ? in_data_byte : 8'd0;
        end
        bip_nxt  = BYTE_BLUE;
        held_nxt = '0;
        if (rle_r) begin
          if (is_run_r) begin
            cnt        = (pkt_left_r == 8'd0) ? 8'd1 : pkt_left_r;
            left_after = 8'd0;
          end else if (pkt_left_r != 8'd0) begin
            left_after = pkt_left_r - 8'd1;
          end
          if (remain_r < {24'd0, cnt}) begin
            cnt = remain_r[7:0];
          end
          pkt_left_nxt = left_after;
          if (left_after == 8'd0) begin
            awaiting_nxt = 1'b1;
          end
        end
        first_nxt     = decoded_r;
        count_nxt     = cnt;
        done_nxt      = ({24'd0, cnt} == remain_r);
        decoded_nxt   = decoded_r + {24'd0, cnt};
        remain_nxt    = remain_r - {24'd0, cnt};
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 16'd1;
      height_r    <= 16'd1;
      alpha_en_r  <= 1'b0;
      rle_r       <= 1'b1;
      awaiting_r  <= 1'b1;
      is_run_r    <= 1'b0;
      pkt_left_r  <= '0;
      bip_r       <= BYTE_BLUE;
      held_r      <= '0;
      decoded_r   <= '0;
      remain_r    <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      alpha_en_r  <= alpha_en_nxt;
      rle_r       <= rle_nxt;
      awaiting_r  <= awaiting_nxt;
      is_run_r    <= is_run_nxt;
      pkt_left_r  <= pkt_left_nxt;
      bip_r       <= bip_nxt;
      held_r      <= held_nxt;
      decoded_r   <= decoded_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    alpha_r <= alpha_nxt;
    first_r <= first_nxt;
    count_r <= count_nxt;
    done_r  <= done_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_alpha        = alpha_r;
  assign out_first_pixel  = first_r;
  assign out_repeat_count = count_r;
  assign out_image_done   = done_r;

  a_remain_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr_en |=> remain_r <= $past(remain_r))
    else $error("pixels remaining grew without a register write");

  a_bip_range: assert property (@(posedge clk) disable iff (!rst_n)
    !alpha_en_r |-> bip_r != BYTE_ALPHA)
    else $error("fourth byte slot used without alpha");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_r != 8'd0 && count_r <= RUN_HDR_MIN))
    else $error("repeat count out of range");

  a_header_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_wr_en && rle_r && awaiting_r) |=> !out_valid_r)
    else $error("packet header produced a pixel");

  a_done_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_wr_en && done_nxt && out_valid_nxt && !(out_valid_r && !out_ready))
      |=> remain_r == 32'd0)
    else $error("image done flagged with pixels left");

endmodule

// ----- tb/tga_rle_pixel_decoder_top_test.sv -----
// Self-checking testbench for the TGA run-length pixel decoder with a built-in predictor.
module tga_rle_pixel_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tga_rle_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_ITEMS  = 500;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] first_pixel;
    logic [7:0]  repeat_count;
    logic        image_done;
  } pixel_run_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_data_byte = 8'd0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic [7:0]            out_alpha;
  logic [31:0]           out_first_pixel;
  logic [7:0]            out_repeat_count;
  logic                  out_image_done;

  tga_rle_pixel_decoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_first_pixel  (out_first_pixel),
    .out_repeat_count (out_repeat_count),
    .out_image_done   (out_image_done)
  );

  always #5 clk = ~clk;

  logic [15:0] img_w;
  logic [15:0] img_h;
  logic        alpha_on;
  logic        rle_on;
  logic        hdr_wait;
  logic        run_pkt;
  logic [7:0]  pkt_left;
  logic [1:0]  byte_idx;
  logic [23:0] bgr_held;
  logic [31:0] pixels_out;

  logic [7:0]  pending_bytes [$];
  logic [7:0]  stage [$];
  pixel_run_t  pixels_due [$];

  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  bit          steady = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned hold_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned rand_items = 0;

  function automatic void restart_image();
    hdr_wait   = 1'b1;
    run_pkt    = 1'b0;
    pkt_left   = 8'd0;
    byte_idx   = BYTE_BLUE;
    bgr_held   = 24'd0;
    pixels_out = 32'd0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_IMAGE_WIDTH:      img_w = val[15:0];
      CFG_IMAGE_HEIGHT:     img_h = val[15:0];
      CFG_HAS_ALPHA:        alpha_on = val[0];
      CFG_RUN_LENGTH_CODED: rle_on = val[0];
      default:              return;
    endcase
    restart_image();
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output pixel_run_t px);
    logic [31:0] total;
    logic [31:0] remaining;
    logic [31:0] cnt;
    bit          last;
    total = {16'd0, img_w} * {16'd0, img_h};
    px = '0;
    if (pixels_out >= total) return 1'b0;
    if (rle_on && hdr_wait) begin
      if (b < RUN_HDR_MIN) begin
        run_pkt  = 1'b0;
        pkt_left = b + 8'd1;
      end else begin
        run_pkt  = 1'b1;
        pkt_left = b - RUN_HDR_BIAS;
      end
      hdr_wait = 1'b0;
      byte_idx = BYTE_BLUE;
      bgr_held = 24'd0;
      return 1'b0;
    end
    last = alpha_on ? (byte_idx == BYTE_ALPHA) : (byte_idx >= BYTE_RED);
    if (!last) begin
      bgr_held = bgr_held | ({16'd0, b} << (8 * byte_idx));
      byte_idx = byte_idx + 2'd1;
      return 1'b0;
    end
    px.blue  = bgr_held[7:0];
    px.green = bgr_held[15:8];
    if (byte_idx == BYTE_RED) begin
      px.red   = b;
      px.alpha = 8'd0;
    end else begin
      px.red   = bgr_held[23:16];
      px.alpha = alpha_on ? b : 8'd0;
    end
    byte_idx  = BYTE_BLUE;
    bgr_held  = 24'd0;
    remaining = total - pixels_out;
    cnt       = 32'd1;
    if (rle_on) begin
      if (run_pkt) begin
        cnt = {24'd0, pkt_left};
        if (cnt == 32'd0) cnt = 32'd1;
        pkt_left = 8'd0;
      end else if (pkt_left > 8'd0) begin
        pkt_left = pkt_left - 8'd1;
      end
      if (cnt > remaining) cnt = remaining;
      if (pkt_left == 8'd0) hdr_wait = 1'b1;
    end
    px.first_pixel  = pixels_out;
    px.repeat_count = cnt[7:0];
    pixels_out      = pixels_out + cnt;
    px.image_done   = (pixels_out == total);
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
    end else if (src_gap > 0) begin
      in_valid <= 1'b0;
      src_gap--;
    end else if (pending_bytes.size() > 0) begin
      in_valid     <= 1'b1;
      in_data_byte <= pending_bytes.pop_front();
      src_gap = steady ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if (sink_gap > 0) begin
      out_ready <= 1'b0;
      sink_gap--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_gap = pick_gap();
    end
  end

  always @(posedge clk) begin : monitor
    pixel_run_t got;
    pixel_run_t want;
    pixel_run_t pred;
    if (!rst_n) begin
      in_fire  = 1'b0;
      out_fire = 1'b0;
    end else begin
      in_fire  = in_valid && in_ready;
      out_fire = out_valid && out_ready;
      if (out_fire) begin
        got = '{out_red, out_green, out_blue, out_alpha, out_first_pixel,
                out_repeat_count, out_image_done};
        if (pixels_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel result: r=%h g=%h b=%h a=%h first=%0d cnt=%0d done=%0b",
                     got.red, got.green, got.blue, got.alpha, got.first_pixel,
                     got.repeat_count, got.image_done);
        end else begin
          want = pixels_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("pixel mismatch: expected r=%h g=%h b=%h a=%h first=%0d cnt=%0d done=%0b",
                       want.red, want.green, want.blue, want.alpha, want.first_pixel,
                       want.repeat_count, want.image_done);
              $display("                actual   r=%h g=%h b=%h a=%h first=%0d cnt=%0d done=%0b",
                       got.red, got.green, got.blue, got.alpha, got.first_pixel,
                       got.repeat_count, got.image_done);
            end
          end
        end
      end
      if (in_fire && decode_byte(in_data_byte, pred)) pixels_due.insert(pixels_due.size(), pred);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || pixels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
  endtask

  task automatic stage_byte(input logic [7:0] b);
    stage.insert(stage.size(), b);
  endtask

  task automatic add_pixel(input bit a);
    repeat (a ? 4 : 3) stage_byte(8'($urandom));
  endtask

  task automatic add_noise(input int unsigned n);
    repeat (n) stage_byte(8'($urandom));
  endtask

  task automatic gen_packets(input int unsigned total, input int unsigned cap, input bit a);
    int unsigned covered;
    int unsigned cnt;
    covered = 0;
    while (covered < total && stage.size() < cap) begin
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
      if ($urandom_range(0, 1) == 1) begin
        stage_byte(8'(cnt + RUN_HDR_BIAS));
        add_pixel(a);
        covered += cnt;
      end else begin
        stage_byte(8'(cnt - 1));
        repeat (cnt) begin
          if (stage.size() >= cap) break;
          add_pixel(a);
          covered++;
        end
      end
    end
  endtask

  task automatic gen_pixels(input int unsigned total, input int unsigned cap, input bit a);
    int unsigned n;
    n = 0;
    while (n < total && stage.size() < cap) begin
      add_pixel(a);
      n++;
    end
  endtask

  task automatic send_stage(input bit split);
    int unsigned cut;
    cut = split ? $urandom_range(0, stage.size()) : stage.size();
    rand_items += stage.size();
    for (int unsigned i = 0; i < cut; i++) put(stage[i]);
    if (split) begin
      drain();
      write_reg(8'($urandom_range(4, 255)), 16'($urandom));
    end
    for (int unsigned i = cut; i < stage.size(); i++) put(stage[i]);
    stage.delete();
  endtask

  initial begin
    logic [15:0] w;
    logic [15:0] h;
    bit          a;
    bit          rl;
    bit          split;
    bit          big;
    int unsigned total;
    int unsigned kind;
    int unsigned phase;
    img_w    = 16'd1;
    img_h    = 16'd1;
    alpha_on = 1'b0;
    rle_on   = 1'b1;
    restart_image();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    put(8'h00); put(8'h00); put(8'hFF); put(8'h80);
    put(8'hFF);
    drain();

    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    write_reg(CFG_HAS_ALPHA, 16'd1);
    put(8'hFF); put(8'h01); put(8'h02); put(8'h03); put(8'hFE);
    put(8'h55);
    drain();

    write_reg(CFG_IMAGE_HEIGHT, 16'd1);
    write_reg(CFG_HAS_ALPHA, 16'd0);
    put(8'h7F);
    put(8'hA5); put(8'h5A); put(8'h0F);
    put(8'hF0); put(8'h3C); put(8'hC3);
    put(8'h99);
    drain();

    write_reg(CFG_RUN_LENGTH_CODED, 16'd0);
    put(8'h11); put(8'h22); put(8'h33);
    drain();
    write_reg(CFG_IMAGE_WIDTH, 16'd0);
    put(8'h44); put(8'h77);
    drain();

    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      phase++;
      big = (phase % 16 == 3);
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin w = 16'hFFFF; h = 16'hFFFF; end
        1: begin w = 16'hFFFF; h = 16'($urandom_range(1, 3)); end
        2: begin w = 16'd1; h = 16'd1; end
        3: begin
          w = 16'($urandom_range(0, 3));
          h = (w == 16'd0) ? 16'($urandom_range(1, 3)) : 16'd0;
        end
        default: begin w = 16'($urandom_range(1, 6)); h = 16'($urandom_range(1, 4)); end
      endcase
      a  = 1'($urandom_range(0, 1));
      rl = ($urandom_range(0, 3) != 0);
      if (big) begin
        w  = 16'hFFFF;
        h  = 16'd2;
        rl = 1'b0;
      end
      write_reg(CFG_IMAGE_WIDTH, w);
      write_reg(CFG_IMAGE_HEIGHT, h);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_HAS_ALPHA, (16'($urandom) & 16'hFFFE) | 16'(a));
        write_reg(CFG_RUN_LENGTH_CODED, (16'($urandom) & 16'hFFFE) | 16'(rl));
      end else begin
        write_reg(CFG_HAS_ALPHA, 16'(a));
        write_reg(CFG_RUN_LENGTH_CODED, 16'(rl));
      end
      total  = {16'd0, w} * {16'd0, h};
      steady = ($urandom_range(0, 4) == 0);
      split  = ($urandom_range(0, 5) == 0);
      kind   = $urandom_range(0, 9);
      if (big) begin
        gen_pixels(total, 120, a);
      end else if (total == 0 || kind == 9) begin
        add_noise($urandom_range(5, 20));
      end else if (kind == 8) begin
        if (rl) gen_packets(total, $urandom_range(1, 10), a);
        else gen_pixels(total, $urandom_range(1, 10), a);
      end else begin
        if (rl) gen_packets(total, 80, a);
        else gen_pixels(total, 80, a);
        if (kind == 7) add_noise($urandom_range(1, 6));
      end
      if (big) hold_req++;
      send_stage(split && !big);
      drain();
    end

    steady = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (pixels_due.size() != 0) begin
      $display("%0d expected pixel results never arrived", pixels_due.size());
      mismatches += pixels_due.size();
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tga_rle_pkg.sv
hw/rtl/tga_rle_pixel_decoder_top.sv
tb/tga_rle_pixel_decoder_top_test.sv
